// ===== rtl/icmpnat_pkg.sv =====
package icmpnat_pkg;

  localparam int unsigned TableEntriesDef = 8;
  localparam int unsigned WheelSlotsDef   = 5;
  localparam logic [15:0] TtlDecAdj       = 16'hFEFF;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_REPLY   = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_CREATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCHED   = 3'd3,
    ST_UNMATCHED = 3'd4,
    ST_TICK      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN
  } fsm_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] remote_addr;
    logic [31:0] local_addr;
    logic [15:0] echo_id;
    logic [15:0] fresh_id;
    logic [15:0] icmp_checksum;
    logic [15:0] ip_checksum;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id_out;
    logic [15:0] icmp_checksum_out;
    logic [15:0] ip_checksum_out;
    logic [31:0] guest_addr_out;
    logic [3:0]  expired_count;
    logic [3:0]  entries_in_use;
  } out_t;

  // ones-complement fold with full end-around carry
  function automatic logic [15:0] fold32(logic [31:0] x);
    logic [16:0] s1;
    logic [16:0] s2;
    logic [16:0] s3;
    s1 = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
    s3 = {1'b0, s2[15:0]} + {16'b0, s2[16]};
    return s3[15:0];
  endfunction

  function automatic logic [15:0] patch16(logic [15:0] cks, logic [15:0] oldv,
                                          logic [15:0] newv);
    logic [31:0] s;
    s = {16'b0, ~cks} + {16'b0, ~oldv} + {16'b0, newv};
    return ~fold32(s);
  endfunction

endpackage

// ===== rtl/icmpnat_ram.sv =====
module icmpnat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/icmp_echo_nat_session_table_unit.sv =====
// icmp echo nat session table, state in one synchronous ram
// a request, reply or tick on a non-empty table scans each entry with one ram read,
// the read data registered in the ram, then takes a result step; a tick on an empty
// table goes straight to the result step; one item at a time, set by the single
// ram read port; no new item is taken until the result is in the output register
// reset: valid bits, session count, wheel position and control clear at once
module icmp_echo_nat_session_table_unit #(
  parameter int unsigned TableEntries = icmpnat_pkg::TableEntriesDef,
  parameter int unsigned WheelSlots   = icmpnat_pkg::WheelSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  icmpnat_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output icmpnat_pkg::out_t  out_data_o
);
  import icmpnat_pkg::*;

  localparam int unsigned IW = TableEntries > 1 ? $clog2(TableEntries) : 1;
  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam int unsigned SW = $clog2(WheelSlots);
  localparam int unsigned WW = 96 + 2 * SW;

  fsm_e             state_q, state_d;
  in_t              item_q;
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    count_q;
  logic [SW-1:0]    cur_q;
  logic [TableEntries-1:0] valid_q;
  logic [IW-1:0]    rank_q [TableEntries];
  logic             found_q;
  logic [IW-1:0]    hit_idx_q;
  logic [WW-1:0]    hit_word_q;
  logic [3:0]       expired_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [WW-1:0]    ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [WW-1:0]    ram_rdata;

  logic             accept;
  logic             out_free;
  logic [IW-1:0]    pidx;
  logic             proc;
  logic [31:0]      rd_ga, rd_ra;
  logic [15:0]      rd_gid, rd_hid;
  logic [SW-1:0]    rd_slot, rd_chain;
  logic             rd_valid;
  logic             req_match, rep_match, tick_hit, tick_drop;
  logic [IW-1:0]    free_idx;
  logic             table_full;
  logic [15:0]      fin_id, fin_hid_or_gid;

  icmpnat_ram #(
    .Width (WW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept      = in_valid_i && (state_q == FSM_IDLE);
  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign rd_ga    = ram_rdata[WW-1 -: 32];
  assign rd_ra    = ram_rdata[WW-33 -: 32];
  assign rd_gid   = ram_rdata[2*SW+31 -: 16];
  assign rd_hid   = ram_rdata[2*SW+15 -: 16];
  assign rd_slot  = ram_rdata[2*SW-1 -: SW];
  assign rd_chain = ram_rdata[SW-1:0];

  // data of entry cnt-1 is on the ram output while in scan
  assign proc     = (state_q == FSM_SCAN) && (cnt_q != '0);
  assign pidx     = IW'(cnt_q - CW'(1));
  assign rd_valid = valid_q[pidx];

  assign req_match = proc && rd_valid && (item_q.func == FUNC_REQUEST) &&
                     (rd_gid == item_q.echo_id) && (rd_ra == item_q.remote_addr) &&
                     (rd_ga == item_q.local_addr) && !found_q;
  assign rep_match = proc && rd_valid && (item_q.func == FUNC_REPLY) &&
                     (rd_hid == item_q.echo_id) && (rd_ra == item_q.remote_addr) &&
                     (!found_q || (rank_q[pidx] < rank_q[hit_idx_q]));
  assign tick_hit  = proc && rd_valid && (item_q.func == FUNC_TICK) && (rd_chain == cur_q);
  assign tick_drop = tick_hit && (rd_slot == cur_q);

  always_comb begin
    free_idx = '0;
    for (int k = TableEntries - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx = IW'(k);
      end
    end
  end
  assign table_full = &valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept && in_data_i.func != FUNC_NONE) begin
          if (in_data_i.func == FUNC_TICK && count_q == '0) begin
            state_d = FSM_FIN;
          end else begin
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (cnt_q == CW'(TableEntries)) begin
          state_d = FSM_FIN;
        end
      end
      FSM_FIN: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr = cnt_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = {ram_rdata[WW-1:SW], rd_slot};
    if (state_q == FSM_SCAN) begin
      ram_we = tick_hit && !tick_drop;
    end else if (state_q == FSM_FIN && out_free && item_q.func == FUNC_REQUEST) begin
      if (found_q) begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q;
        ram_wdata = {hit_word_q[WW-1:2*SW], cur_q, hit_word_q[SW-1:0]};
      end else if (!table_full) begin
        ram_we    = 1'b1;
        ram_waddr = free_idx;
        ram_wdata = {item_q.local_addr, item_q.remote_addr, item_q.echo_id,
                     item_q.fresh_id, cur_q, cur_q};
      end
    end
  end

  assign fin_hid_or_gid = found_q ? hit_word_q[2*SW+15 -: 16] : item_q.fresh_id;
  assign fin_id         = hit_word_q[2*SW+31 -: 16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      valid_q     <= '0;
      found_q     <= 1'b0;
      expired_q   <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < TableEntries; k++) begin
        rank_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        FSM_IDLE: begin
          if (accept) begin
            item_q    <= in_data_i;
            cnt_q     <= '0;
            found_q   <= 1'b0;
            expired_q <= '0;
            if (in_data_i.func == FUNC_TICK && count_q != '0) begin
              cur_q <= (cur_q == SW'(WheelSlots - 1)) ? '0 : cur_q + SW'(1);
            end
          end
        end
        FSM_SCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (req_match || rep_match) begin
            found_q    <= 1'b1;
            hit_idx_q  <= pidx;
            hit_word_q <= ram_rdata;
          end
          if (tick_drop) begin
            valid_q[pidx] <= 1'b0;
            count_q       <= count_q - CW'(1);
            expired_q     <= expired_q + 4'd1;
            for (int k = 0; k < TableEntries; k++) begin
              if (valid_q[k] && IW'(k) != pidx && rank_q[k] > rank_q[pidx]) begin
                rank_q[k] <= rank_q[k] - IW'(1);
              end
            end
          end
        end
        FSM_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '0;
            case (item_q.func)
              FUNC_REQUEST: begin
                if (!found_q && table_full) begin
                  out_q.status         <= ST_FULL;
                  out_q.entries_in_use <= 4'(count_q);
                end else begin
                  out_q.status            <= found_q ? ST_REFRESHED : ST_CREATED;
                  out_q.id_out            <= fin_hid_or_gid;
                  out_q.icmp_checksum_out <= patch16(item_q.icmp_checksum, item_q.echo_id,
                                                     fin_hid_or_gid);
                  if (found_q) begin
                    out_q.entries_in_use <= 4'(count_q);
                  end else begin
                    out_q.entries_in_use <= 4'(count_q + CW'(1));
                    count_q              <= count_q + CW'(1);
                    valid_q[free_idx]    <= 1'b1;
                    for (int k = 0; k < TableEntries; k++) begin
                      if (valid_q[k]) begin
                        rank_q[k] <= rank_q[k] + IW'(1);
                      end
                    end
                    rank_q[free_idx] <= '0;
                  end
                end
              end
              FUNC_REPLY: begin
                out_q.entries_in_use <= 4'(count_q);
                if (found_q) begin
                  out_q.status            <= ST_MATCHED;
                  out_q.id_out            <= fin_id;
                  out_q.guest_addr_out    <= hit_word_q[WW-1 -: 32];
                  out_q.icmp_checksum_out <= patch16(item_q.icmp_checksum, item_q.echo_id,
                                                     fin_id);
                  out_q.ip_checksum_out   <= ~fold32({16'b0, ~item_q.ip_checksum} +
                    {16'b0, fold32(~item_q.local_addr)} +
                    {16'b0, fold32(hit_word_q[WW-1 -: 32])} + {16'b0, TtlDecAdj});
                end else begin
                  out_q.status <= ST_UNMATCHED;
                end
              end
              default: begin
                out_q.status         <= ST_TICK;
                out_q.expired_count  <= expired_q;
                out_q.entries_in_use <= 4'(count_q);
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule
